/* rtl/fcd_pkg.sv */
// shared types, constants and microcode rom for the centroid defuzzifier
package fcd_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int MAX_UNIVERSE_DEF  = 128;

  localparam int LEFT_EDGE  = 10;
  localparam int MID_POINT  = 30;
  localparam int RIGHT_EDGE = 50;
  localparam int RAMP_SPAN  = 20;
  localparam int KW         = $clog2(RAMP_SPAN + 1);

  localparam int           CFG_AW       = 3;
  localparam int           CFG_DW       = 32;
  localparam logic [7:0]   USIZE_RESET  = 8'd100;

  typedef enum logic [0:0] {
    REG_UNIVERSE_SIZE = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [8:0] left_strength;
    logic [8:0] center_strength;
    logic [8:0] right_strength;
  } in_req_t;

  typedef struct packed {
    logic [6:0] crisp_output;
    logic       empty_area;
  } out_res_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ACC   = 3'd1,
    ST_DINIT = 3'd2,
    ST_DIV   = 3'd3,
    ST_OUT   = 3'd4
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_NO_REQ   = 3'd1,
    C_MORE_PTS = 3'd2,
    C_DIV_MORE = 3'd3,
    C_OUT_BUSY = 3'd4
  } cond_t;

  typedef struct packed {
    logic ld;
    logic acc;
    logic dinit;
    logic div;
    logic out_wr;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic more_pts;
    logic div_more;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    ctrl_t ctl;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  // jump to jmp when cond holds, else go to nxt
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{ctl: '0, cond: C_ALWAYS, jmp: ST_IDLE, nxt: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.ctl.ld = 1'b1;
        w.cond   = C_NO_REQ;
        w.jmp    = ST_IDLE;
        w.nxt    = ST_ACC;
      end
      ST_ACC: begin
        w.ctl.acc = 1'b1;
        w.cond    = C_MORE_PTS;
        w.jmp     = ST_ACC;
        w.nxt     = ST_DINIT;
      end
      ST_DINIT: begin
        w.ctl.dinit = 1'b1;
        w.cond      = C_ALWAYS;
        w.jmp       = ST_DIV;
        w.nxt       = ST_DIV;
      end
      ST_DIV: begin
        w.ctl.div = 1'b1;
        w.cond    = C_DIV_MORE;
        w.jmp     = ST_DIV;
        w.nxt     = ST_OUT;
      end
      ST_OUT: begin
        w.ctl.out_wr = 1'b1;
        w.cond       = C_OUT_BUSY;
        w.jmp        = ST_OUT;
        w.nxt        = ST_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.jmp  = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/fcd_seq.sv */
// microcode sequencer: step counter, rom lookup and conditional jumps
module fcd_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  fcd_pkg::stat_t stat,
  output fcd_pkg::ctrl_t ctrl
);

  fcd_pkg::step_t  step_r;
  fcd_pkg::step_t  step_nxt;
  fcd_pkg::uword_t uw;
  logic            cond_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= fcd_pkg::ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    uw = fcd_pkg::ucode(step_r);
    case (uw.cond)
      fcd_pkg::C_ALWAYS:   cond_hit = 1'b1;
      fcd_pkg::C_NO_REQ:   cond_hit = !stat.in_valid;
      fcd_pkg::C_MORE_PTS: cond_hit = stat.more_pts;
      fcd_pkg::C_DIV_MORE: cond_hit = stat.div_more;
      fcd_pkg::C_OUT_BUSY: cond_hit = stat.out_busy;
      default:             cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? uw.jmp : uw.nxt;
    ctrl     = uw.ctl;
  end

  // the divide loop is only entered from its init step or from itself
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == fcd_pkg::ST_DIV) |->
      ($past(step_r) == fcd_pkg::ST_DINIT || $past(step_r) == fcd_pkg::ST_DIV))
    else $error("divide step entered out of sequence");

  // a request is only taken from the idle step
  a_ld_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ld |-> (step_r == fcd_pkg::ST_IDLE))
    else $error("load issued outside idle step");

  // after the divide loop the output step always follows
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == fcd_pkg::ST_DIV && !stat.div_more) |=> (step_r == fcd_pkg::ST_OUT))
    else $error("divide loop did not hand over to output");

endmodule

/* rtl/fcd_datapath.sv */
// datapath: membership evaluation, accumulators, serial divider, result register
module fcd_datapath #(
  parameter int FRACTION_BITS = fcd_pkg::FRACTION_BITS_DEF,
  parameter int MAX_UNIVERSE  = fcd_pkg::MAX_UNIVERSE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fcd_pkg::ctrl_t    ctrl,
  output fcd_pkg::stat_t    stat,
  input  logic [7:0]        usize,
  input  logic              in_valid,
  output logic              in_ready,
  input  fcd_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fcd_pkg::out_res_t out_data
);

  localparam int ONE = 1 << FRACTION_BITS;
  localparam int MW  = FRACTION_BITS + 1;
  localparam int XW  = $clog2(MAX_UNIVERSE) + 1;
  localparam int DW  = XW + MW;
  localparam int NW  = 2 * XW + MW;
  localparam int CW  = $clog2(XW);
  localparam int KW  = fcd_pkg::KW;

  logic [MW-1:0] ramp_tbl [0:fcd_pkg::RAMP_SPAN];

  for (genvar k = 0; k <= fcd_pkg::RAMP_SPAN; k++) begin : g_ramp
    assign ramp_tbl[k] = MW'((k * ONE) / fcd_pkg::RAMP_SPAN);
  end

  logic [MW-1:0] ls_r, cs_r, rs_r;
  logic [XW-1:0] n_r, x_r;
  logic [NW-1:0] num_r, rem_r, dsh_r;
  logic [DW-1:0] den_r;
  logic [XW-1:0] q_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  fcd_pkg::out_res_t out_r;

  logic          accept;
  logic          more;
  logic          out_busy;
  logic          out_wr;
  logic [XW-1:0] d_l, d_cu, d_cd, d_r;
  logic [MW-1:0] l_m, c_m, r_m, l_c, c_c, r_c, mu;
  logic [DW-1:0] prod;
  logic [XW-1:0] q_sat;
  fcd_pkg::out_res_t res;

  function automatic logic [MW-1:0] sat_s(input logic [8:0] s);
    logic [MW-1:0] v;
    if (32'(s) > 32'(ONE)) begin
      v = MW'(ONE);
    end else begin
      v = MW'(s);
    end
    return v;
  endfunction

  assign accept   = in_valid && ctrl.ld;
  assign in_ready = ctrl.ld;
  assign more     = x_r < n_r;
  assign out_busy = out_valid_r && !out_ready;
  assign out_wr   = ctrl.out_wr && !out_busy;

  assign stat.in_valid = in_valid;
  assign stat.more_pts = more;
  assign stat.div_more = cnt_r != '0;
  assign stat.out_busy = out_busy;

  // membership of the three fixed sets at the current point, clipped and merged
  always_comb begin
    d_l  = XW'(fcd_pkg::MID_POINT) - x_r;
    d_cu = x_r - XW'(fcd_pkg::LEFT_EDGE);
    d_cd = XW'(fcd_pkg::RIGHT_EDGE) - x_r;
    d_r  = x_r - XW'(fcd_pkg::MID_POINT);

    if (x_r <= XW'(fcd_pkg::LEFT_EDGE)) begin
      l_m = MW'(ONE);
    end else if (x_r < XW'(fcd_pkg::MID_POINT)) begin
      l_m = ramp_tbl[d_l[KW-1:0]];
    end else begin
      l_m = '0;
    end

    if (x_r >= XW'(fcd_pkg::LEFT_EDGE) && x_r <= XW'(fcd_pkg::MID_POINT)) begin
      c_m = ramp_tbl[d_cu[KW-1:0]];
    end else if (x_r > XW'(fcd_pkg::MID_POINT) && x_r < XW'(fcd_pkg::RIGHT_EDGE)) begin
      c_m = ramp_tbl[d_cd[KW-1:0]];
    end else begin
      c_m = '0;
    end

    if (x_r >= XW'(fcd_pkg::RIGHT_EDGE)) begin
      r_m = MW'(ONE);
    end else if (x_r > XW'(fcd_pkg::MID_POINT)) begin
      r_m = ramp_tbl[d_r[KW-1:0]];
    end else begin
      r_m = '0;
    end

    l_c = (l_m < ls_r) ? l_m : ls_r;
    c_c = (c_m < cs_r) ? c_m : cs_r;
    r_c = (r_m < rs_r) ? r_m : rs_r;
    mu  = (l_c > c_c) ? l_c : c_c;
    mu  = (mu > r_c) ? mu : r_c;

    prod = {{MW{1'b0}}, x_r} * {{XW{1'b0}}, mu};
  end

  always_comb begin
    q_sat = (32'(q_r) > 32'd127) ? XW'(127) : q_r;
    if (den_r == '0) begin
      res.crisp_output = '0;
      res.empty_area   = 1'b1;
    end else begin
      res.crisp_output = q_sat[6:0];
      res.empty_area   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ls_r  <= sat_s(in_data.left_strength);
      cs_r  <= sat_s(in_data.center_strength);
      rs_r  <= sat_s(in_data.right_strength);
      n_r   <= (32'(usize) > 32'(MAX_UNIVERSE)) ? XW'(MAX_UNIVERSE) : XW'(usize);
      x_r   <= '0;
      num_r <= '0;
      den_r <= '0;
    end else if (ctrl.acc && more) begin
      num_r <= num_r + NW'(prod);
      den_r <= den_r + DW'(mu);
      x_r   <= x_r + XW'(1);
    end

    // restoring divide, one quotient bit per step, msb first
    if (ctrl.dinit) begin
      rem_r <= num_r;
      dsh_r <= NW'(den_r) << (XW - 1);
      q_r   <= '0;
      cnt_r <= CW'(XW - 1);
    end else if (ctrl.div) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[XW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[XW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end

    if (out_wr) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // the point counter never runs past the universe size
  a_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.acc |-> (x_r <= n_r))
    else $error("point counter beyond universe");

  // the divide leaves a remainder below the divisor
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.out_wr && den_r != '0) |-> (rem_r < NW'(den_r)))
    else $error("divide remainder not below divisor");

  // a zero area implies a zero moment
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.out_wr |-> (den_r != '0 || num_r == '0))
    else $error("zero area with nonzero moment");

endmodule

/* rtl/fuzzy_centroid_defuzzifier_unit.sv */
// top level of the three-set centroid defuzzifier with its config register
//
//  port group   dir  handshake           payload
//  in_*         in   in_valid/in_ready   fcd_pkg::in_req_t (three strengths)
//  out_*        out  out_valid/out_ready fcd_pkg::out_res_t (centroid, empty flag)
//  apb          in   psel/penable/pready universe_size at byte address 0
//
//  a request runs the accumulate loop over n = min(universe_size, MAX_UNIVERSE) points
//  on the shared multiply-add, then the serial divider yields XW = clog2(MAX_UNIVERSE)+1
//  quotient bits, msb first. reset is synchronous, active low, and returns the
//  sequencer to idle with universe_size = 100. a finished result sits in the output
//  register while the next request is accepted; a stalled output holds the
//  sequencer in its output step until the register frees up
module fuzzy_centroid_defuzzifier_unit #(
  parameter int FRACTION_BITS = fcd_pkg::FRACTION_BITS_DEF,
  parameter int MAX_UNIVERSE  = fcd_pkg::MAX_UNIVERSE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fcd_pkg::in_req_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fcd_pkg::out_res_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fcd_pkg::CFG_AW-1:0] paddr,
  input  logic [fcd_pkg::CFG_DW-1:0] pwdata,
  output logic [fcd_pkg::CFG_DW-1:0] prdata,
  output logic                      pready
);

  fcd_pkg::ctrl_t   ctrl;
  fcd_pkg::stat_t   stat;
  fcd_pkg::reg_idx_t reg_idx;
  logic [7:0]       usize_r;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = fcd_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usize_r <= fcd_pkg::USIZE_RESET;
    end else if (cfg_wr && reg_idx == fcd_pkg::REG_UNIVERSE_SIZE) begin
      usize_r <= pwdata[7:0];
    end
  end

  always_comb begin
    case (reg_idx)
      fcd_pkg::REG_UNIVERSE_SIZE: prdata = {{(fcd_pkg::CFG_DW - 8){1'b0}}, usize_r};
      default:                    prdata = '0;
    endcase
  end

  fcd_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  fcd_datapath #(
    .FRACTION_BITS(FRACTION_BITS),
    .MAX_UNIVERSE (MAX_UNIVERSE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .stat     (stat),
    .usize    (usize_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

/* test/testbench.sv */
// self-checking testbench for the three-set centroid defuzzifier
`timescale 1ns / 100ps

module testbench;
  import fcd_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 600;
  localparam int DRAIN_CYCLES  = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES    = 12;
  localparam int HOLD_AT_A     = 300;
  localparam int HOLD_AT_B     = 1000;
  localparam int STRENGTH_ONE  = 1 << FRACTION_BITS_DEF;

  localparam out_res_t EMPTY_RES = '{crisp_output: 7'd0, empty_area: 1'b1};
  localparam out_res_t ZERO_RES  = '{crisp_output: 7'd0, empty_area: 1'b0};

  typedef struct {
    logic [7:0] usize;
    logic [8:0] left_s;
    logic [8:0] center_s;
    logic [8:0] right_s;
    bit         typed;
    out_res_t   want;
  } dir_row_t;

  // usize, left, center, right, typed, expected
  dir_row_t dir_rows [0:19] = '{
    '{8'd100, 9'd0,   9'd0,   9'd0,   1'b1, EMPTY_RES},
    '{8'd100, 9'd256, 9'd256, 9'd256, 1'b0, ZERO_RES},
    '{8'd100, 9'd511, 9'd511, 9'd511, 1'b0, ZERO_RES},
    '{8'd100, 9'd256, 9'd0,   9'd0,   1'b0, ZERO_RES},
    '{8'd100, 9'd0,   9'd256, 9'd0,   1'b0, ZERO_RES},
    '{8'd100, 9'd0,   9'd0,   9'd256, 1'b0, ZERO_RES},
    '{8'd100, 9'd257, 9'd0,   9'd0,   1'b0, ZERO_RES},
    '{8'd100, 9'd1,   9'd1,   9'd1,   1'b0, ZERO_RES},
    '{8'd100, 9'd0,   9'd0,   9'd1,   1'b0, ZERO_RES},
    '{8'd100, 9'd300, 9'd128, 9'd511, 1'b0, ZERO_RES},
    '{8'd0,   9'd511, 9'd511, 9'd511, 1'b1, EMPTY_RES},
    '{8'd1,   9'd256, 9'd0,   9'd0,   1'b1, ZERO_RES},
    '{8'd1,   9'd0,   9'd256, 9'd256, 1'b1, EMPTY_RES},
    '{8'd1,   9'd1,   9'd0,   9'd0,   1'b1, ZERO_RES},
    '{8'd11,  9'd0,   9'd256, 9'd0,   1'b1, EMPTY_RES},
    '{8'd31,  9'd255, 9'd255, 9'd255, 1'b0, ZERO_RES},
    '{8'd50,  9'd0,   9'd0,   9'd256, 1'b0, ZERO_RES},
    '{8'd128, 9'd0,   9'd0,   9'd256, 1'b0, ZERO_RES},
    '{8'd255, 9'd0,   9'd0,   9'd511, 1'b0, ZERO_RES},
    '{8'd200, 9'd511, 9'd0,   9'd511, 1'b0, ZERO_RES}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_req_t             in_data;
  logic                out_valid;
  logic                out_ready;
  out_res_t            out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  out_res_t            pending_centroids[$];
  logic [7:0]          usize_shadow;
  bit                  in_steady;
  bit                  out_steady;
  int                  fail_count;
  int                  sent_count;
  int                  results_seen;
  int                  empty_seen;
  int                  cfg_writes;
  int                  stall_cycles;
  int                  usize_plan [NUM_PHASES] = '{100, 128, 1, 64, 0, 255, 31, 200, 50, 129, 7, 96};

  fuzzy_centroid_defuzzifier_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int ramp_level(int k);
    return (k * STRENGTH_ONE) / RAMP_SPAN;
  endfunction

  // exact integer centroid of the clipped three-set union
  function automatic out_res_t centroid_of(in_req_t req, logic [7:0] usize);
    int       ls, cs, rs, n, l, c, r, mu;
    longint   num, den, q;
    out_res_t res;
    ls  = (req.left_strength > STRENGTH_ONE) ? STRENGTH_ONE : int'(req.left_strength);
    cs  = (req.center_strength > STRENGTH_ONE) ? STRENGTH_ONE : int'(req.center_strength);
    rs  = (req.right_strength > STRENGTH_ONE) ? STRENGTH_ONE : int'(req.right_strength);
    n   = (usize > MAX_UNIVERSE_DEF) ? MAX_UNIVERSE_DEF : int'(usize);
    num = 0;
    den = 0;
    for (int x = 0; x < n; x++) begin
      l = 0;
      c = 0;
      r = 0;
      if (x <= LEFT_EDGE) l = STRENGTH_ONE;
      else if (x < MID_POINT) l = ramp_level(MID_POINT - x);
      if (x >= LEFT_EDGE && x <= MID_POINT) c = ramp_level(x - LEFT_EDGE);
      else if (x > MID_POINT && x < RIGHT_EDGE) c = ramp_level(RIGHT_EDGE - x);
      if (x >= RIGHT_EDGE) r = STRENGTH_ONE;
      else if (x > MID_POINT) r = ramp_level(x - MID_POINT);
      mu = (l < ls) ? l : ls;
      if (((c < cs) ? c : cs) > mu) mu = (c < cs) ? c : cs;
      if (((r < rs) ? r : rs) > mu) mu = (r < rs) ? r : rs;
      num += longint'(x) * mu;
      den += mu;
    end
    if (den == 0) begin
      res = EMPTY_RES;
    end else begin
      q = num / den;
      if (q > 127) q = 127;
      res.crisp_output = q[6:0];
      res.empty_area   = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_gap(bit steady);
    return steady ? 0 : $urandom_range(0, 14);
  endfunction

  // weighted toward the saturation boundary and the fine clip levels
  function automatic logic [8:0] rand_strength();
    logic [8:0] s;
    case ($urandom_range(0, 9))
      0, 1:    s = 9'($urandom_range(0, 511));
      2, 3, 4: s = 9'($urandom_range(0, 256));
      5: begin
        case ($urandom_range(0, 4))
          0:       s = 9'd0;
          1:       s = 9'd255;
          2:       s = 9'd256;
          3:       s = 9'd257;
          default: s = 9'd511;
        endcase
      end
      6, 7:    s = 9'($urandom_range(0, 40));
      default: s = 9'($urandom_range(200, 300));
    endcase
    return s;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_req(in_req_t req, bit typed, out_res_t want);
    int gap;
    gap = pick_gap(in_steady);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = req;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_centroids.push_back(typed ? want : centroid_of(req, usize_shadow));
    sent_count++;
    @(negedge clk);
  endtask

  // drop valid and wait until every outstanding request has its result
  task automatic settle();
    in_valid = 1'b0;
    while (pending_centroids.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [CFG_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CFG_AW'(4 * int'(idx));
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_UNIVERSE_SIZE) usize_shadow = value[7:0];
    cfg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic cfg_read_check(reg_idx_t idx);
    logic [CFG_DW-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = CFG_AW'(4 * int'(idx));
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== {{(CFG_DW-8){1'b0}}, usize_shadow})
      note_failure($sformatf("universe_size readback expected %0d, got %0d",
                             usize_shadow, got));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_universe(int usize);
    logic [CFG_DW-1:0] word;
    word      = $urandom();
    word[7:0] = usize[7:0];
    settle();
    cfg_write(REG_UNIVERSE_SIZE, word);
    cfg_read_check(REG_UNIVERSE_SIZE);
  endtask

  task automatic check_result(out_res_t got);
    out_res_t want;
    results_seen++;
    if (got.empty_area) empty_seen++;
    if (pending_centroids.size() == 0) begin
      note_failure($sformatf("unexpected result crisp=%0d empty=%0d",
                             got.crisp_output, got.empty_area));
      return;
    end
    want = pending_centroids.pop_front();
    if (got.crisp_output !== want.crisp_output || got.empty_area !== want.empty_area)
      note_failure($sformatf("result %0d: expected crisp=%0d empty=%0d, got crisp=%0d empty=%0d",
                             results_seen, want.crisp_output, want.empty_area,
                             got.crisp_output, got.empty_area));
  endtask

  // result side: random stalls, plus two long hold-offs that back up the input
  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) gap = LONG_HOLD;
      else gap = pick_gap(out_steady);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 stall_cycles, pending_centroids.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_req_t req;
    int      items;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_steady    = 1'b0;
    out_steady   = 1'b0;
    fail_count   = 0;
    sent_count   = 0;
    results_seen = 0;
    empty_seen   = 0;
    cfg_writes   = 0;
    usize_shadow = USIZE_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    cfg_read_check(REG_UNIVERSE_SIZE);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].usize != usize_shadow) set_universe(dir_rows[i].usize);
      req.left_strength   = dir_rows[i].left_s;
      req.center_strength = dir_rows[i].center_s;
      req.right_strength  = dir_rows[i].right_s;
      send_req(req, dir_rows[i].typed, dir_rows[i].want);
    end

    // write to the unmapped slot must leave universe_size alone
    settle();
    cfg_write(REG_UNUSED, $urandom());
    cfg_read_check(REG_UNIVERSE_SIZE);

    usize_plan[3]  = $urandom_range(2, 128);
    usize_plan[10] = $urandom_range(0, 255);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_universe(usize_plan[p]);
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      items      = (usize_plan[p] <= 1) ? 25 : 190;
      for (int k = 0; k < items; k++) begin
        req.left_strength   = rand_strength();
        req.center_strength = rand_strength();
        req.right_strength  = rand_strength();
        send_req(req, 1'b0, ZERO_RES);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_centroids.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_centroids.size()));
    $display("run: %0d requests, %0d results (%0d with empty area), %0d register writes",
             sent_count, results_seen, empty_seen, cfg_writes);
    $display("universe sizes from 0 to 255 including saturation, strengths 0 to 511");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
